@@ sv/dhtnse_pkg.sv @@
// ---------------------------------------------------------------------------
// dhtnse_pkg
// shared widths, outcome codes and per-count estimator constants
// ---------------------------------------------------------------------------
package dhtnse_pkg;

   localparam int MAX_NODES_DEF   = 16;
   localparam int MAX_NODES_LIMIT = 64;
   localparam int MIN_NODES       = 4;
   localparam int DIST_W          = 64;
   localparam int NUM_W           = 51;   // 3*Q*Q - V, k up to 64
   localparam int TQ_W            = 19;   // 3*Q, k up to 64
   localparam int SUM_W           = 76;   // rank-weighted sum of Q0.64 distances
   localparam int DEN_W           = SUM_W + TQ_W;
   localparam int QUO_W           = 64;
   localparam int FRAC_SH         = 64;   // numerator is (3QQ - V) * 2^(16+64)

   typedef enum logic [1:0] {
      OUT_VALID = 2'd0,
      OUT_FEW   = 2'd1,
      OUT_ZERO  = 2'd2
   } outcome_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctl_type;

   // numerator (3*Q*Q - V) for k nodes, already scaled by 2^16, zero when not positive
   function automatic logic [NUM_W-1:0] num_of(int k);
      longint unsigned q, v, w, top;
      q = 0;
      v = 0;
      for (int i = 1; i <= k; i++) q = q + longint'(i * i);
      for (int j = 1; j <= k; j++) begin
         w = longint'((k * (k + 1) - (j - 1) * j) / 2);
         v = v + w * w;
      end
      top = 3 * q * q;
      return (top > v) ? NUM_W'((top - v) << 16) : '0;
   endfunction

   // 3*Q for k nodes
   function automatic logic [TQ_W-1:0] tq_of(int k);
      longint unsigned q;
      q = 0;
      for (int i = 1; i <= k; i++) q = q + longint'(i * i);
      return TQ_W'(3 * q);
   endfunction

endpackage

@@ sv/dht_network_size_estimate.sv @@
// ---------------------------------------------------------------------------
// dht_network_size_estimate
// sorted chain of node distances and a rank-weighted size estimator
// ---------------------------------------------------------------------------
// each request is inserted into the sorted chain as it is accepted
// on a request with tlast: a weighted sum over the k slots, scaling in a low and a high half,
// a start step, bit-serial division, capture of the quotient, then the response register
// a zero sum and a set below MIN_NODES skip the division and answer with a zero estimate
// input held from the last request until its result moves into the response register
// synchronous active-high reset empties the chain, the response register and the sequencer
// ---------------------------------------------------------------------------
module dht_network_size_estimate #(
   parameter int MAX_NODES = dhtnse_pkg::MAX_NODES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,    // node_high [63:0], target_high [127:64]
   input  logic          req_tlast,    // last
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,    // estimate [63:0]
   output logic [1:0]    rsp_tuser     // outcome [1:0]
);
   import dhtnse_pkg::*;

   localparam int CW = $clog2(MAX_NODES + 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SUM  = 6'b000010,
      ST_MLO  = 6'b000100,
      ST_MHI  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;     // kept distances
   logic [CW-1:0]      k_ff, k_in;             // node count of the closed set
   logic [CW-1:0]      rank_ff, rank_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [63:0]        est_ff, est_in;
   outcome_type        outc_ff, outc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   outcome_type        rsp_user_ff, rsp_user_in;
   logic               rsp_load;
   logic               mhi_d_ff;
   logic               div_start;
   logic               div_done;
   logic [63:0]        div_quo;
   logic               accept;
   logic [CW-1:0]      count_next;
   logic [63:0]        dist_new;
   cell_ctl_type       ctl;
   logic [69:0]        rank_term;              // rank times slot 0 distance
   logic [37:0]        mul_a;                  // one half of the weighted sum
   logic [56:0]        prod;                   // half sum times 3*Q

   logic [63:0]        cell_value [MAX_NODES];
   logic               cell_gt    [MAX_NODES];
   logic [NUM_W-1:0]   num_rom    [0:MAX_NODES];
   logic [TQ_W-1:0]    tq_rom     [0:MAX_NODES];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign dist_new   = req_tdata[63:0] ^ req_tdata[127:64];
   // a full chain stays full: the largest entry falls off or the new one is dropped
   assign count_next = (count_ff < CW'(MAX_NODES)) ? count_ff + CW'(1) : count_ff;

   // per-count constants, folded at elaboration
   for (genvar g = 0; g <= MAX_NODES; g++) begin : g_rom
      assign num_rom[g] = num_of(g);
      assign tq_rom[g]  = tq_of(g);
   end

   always_comb begin
      ctl.insert = accept;
      ctl.shift  = (state_ff == ST_SUM);
   end

   // chain of sorted slots, slot 0 holds the smallest distance
   for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
      logic [63:0] left_v, right_v;
      logic        left_g, used;
      if (i == 0) begin : g_first
         assign left_v = '0;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_v = cell_value[i-1];
         assign left_g = cell_gt[i-1];
      end
      if (i == MAX_NODES - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_up
         assign right_v = cell_value[i+1];
      end
      assign used = (CW'(i) < count_ff);
      dhtnse_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .slot_used   (used),
         .dist_new    (dist_new),
         .left_value  (left_v),
         .left_gt     (left_g),
         .right_value (right_v),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   // divider starts once the full denominator is registered
   assign div_start = (state_ff == ST_DIV) && mhi_d_ff;

   dhtnse_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_rom[k_ff]),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // small multipliers: rank times distance, and the denominator in two halves
   assign rank_term = {{(70 - CW){1'b0}}, rank_ff} * {6'b0, cell_value[0]};
   assign mul_a     = (state_ff == ST_MHI) ? sum_ff[SUM_W-1:38] : sum_ff[37:0];
   assign prod      = {19'b0, mul_a} * {38'b0, tq_rom[k_ff]};

   // result moves to the response register when it is empty or being taken
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      rank_in   = rank_ff;
      sum_in    = sum_ff;
      den_in    = den_ff;
      est_in    = est_ff;
      outc_in   = outc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = count_next;
               if (req_tlast) begin
                  // close the set: remember k, empty the count for the next set
                  k_in     = count_next;
                  count_in = '0;
                  rank_in  = CW'(1);
                  sum_in   = '0;
                  if (count_next < CW'(MIN_NODES)) begin
                     est_in   = '0;
                     outc_in  = OUT_FEW;
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_SUM;
                  end
               end
            end
         end
         ST_SUM: begin
            // slot 0 drains one distance per cycle in ascending order
            sum_in  = sum_ff + SUM_W'(rank_term);
            rank_in = rank_ff + CW'(1);
            if (rank_ff == k_ff) state_in = ST_MLO;
         end
         ST_MLO: begin
            if (sum_ff == '0) begin
               est_in   = '0;
               outc_in  = OUT_ZERO;
               state_in = ST_OUT;
            end else begin
               den_in   = DEN_W'(prod);
               state_in = ST_MHI;
            end
         end
         ST_MHI: begin
            den_in    = den_ff + (DEN_W'(prod) << 38);
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               est_in   = div_quo;
               outc_in  = OUT_VALID;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response register: holds one result so the next set can stream in
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = est_ff;
         rsp_user_in  = outc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mhi_d_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mhi_d_ff     <= (state_ff == ST_MHI);
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      rank_ff     <= rank_in;
      sum_ff      <= sum_in;
      den_ff      <= den_in;
      est_ff      <= est_in;
      outc_ff     <= outc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a response not taken stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while waiting");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NODES))
      else $error("node count above capacity");

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request taken while estimate in progress");

endmodule

@@ sv/dhtnse_cell.sv @@
// ---------------------------------------------------------------------------
// dhtnse_cell
// one slot of the sorted distance chain: insert from left, drain to left
// ---------------------------------------------------------------------------
module dhtnse_cell (
   input  logic                      clock,
   input  dhtnse_pkg::cell_ctl_type  ctl,
   input  logic                      slot_used,
   input  logic [63:0]               dist_new,
   input  logic [63:0]               left_value,
   input  logic                      left_gt,
   input  logic [63:0]               right_value,
   output logic [63:0]               value,
   output logic                      gt
);
   import dhtnse_pkg::*;

   logic [DIST_W-1:0] value_ff, value_in;

   // an empty slot counts as larger than any new distance
   assign gt = !slot_used || (value_ff > dist_new);

   always_comb begin
      value_in = value_ff;
      if (ctl.insert && gt) begin
         value_in = left_gt ? left_value : dist_new;
      end else if (ctl.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ sv/dhtnse_div.sv @@
// ---------------------------------------------------------------------------
// dhtnse_div
// restoring divider, one quotient bit per cycle, saturating 64-bit quotient
// ---------------------------------------------------------------------------
module dhtnse_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dhtnse_pkg::NUM_W-1:0]  num,
   input  logic [dhtnse_pkg::DEN_W-1:0]  den,
   output logic                          done,
   output logic [63:0]                   quo
);
   import dhtnse_pkg::*;

   localparam int NB = NUM_W + FRAC_SH;   // numerator bits

   logic                busy_ff, busy_in;
   logic [6:0]          bit_ff, bit_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic                ovf_ff, ovf_in;
   logic                done_ff, done_in;
   logic [DEN_W:0]      rem_sh;
   logic                nbit, ge;
   logic [6:0]          bsub;

   always_comb begin
      bsub   = bit_ff - 7'(FRAC_SH);
      nbit   = (bit_ff >= 7'(FRAC_SH)) ? num_ff[bsub[5:0]] : 1'b0;
      rem_sh = {rem_ff, nbit};
      ge     = rem_sh >= {1'b0, den_ff};

      busy_in = busy_ff;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = 7'(NB - 1);
         rem_in  = '0;
         den_in  = den;
         num_in  = num;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         ovf_in = ovf_ff | (ge && (bit_ff >= 7'(QUO_W)));
         bit_in = bit_ff - 7'd1;
         if (bit_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign quo  = ovf_ff ? {QUO_W{1'b1}} : quo_ff;

endmodule
